// ===== src/pldj_pkg.sv =====
`default_nettype none
package pldj_pkg;

   localparam int CordicStagesDefault = 16;
   localparam int AtanEntries = 24;
   localparam int AngW = 33;          // CORDIC x, y, z width, Q.30
   localparam int PrdW = 68;          // product width
   localparam int DivW = 56;          // dividend width of the precompute divider
   localparam int CfgW = 24;

   localparam logic [CfgW-1:0] TwrReset = 24'd131072;
   localparam logic [CfgW-1:0] GrvReset = 24'd642908;
   localparam logic [CfgW-1:0] ArmReset = 24'd65536;
   localparam logic [CfgW-1:0] GyrReset = 24'd65536;

   localparam logic [1:0] CsrTwr = 2'd0;
   localparam logic [1:0] CsrGrv = 2'd1;
   localparam logic [1:0] CsrArm = 2'd2;
   localparam logic [1:0] CsrGyr = 2'd3;

   localparam logic [33:0] Lim34 = 34'h3_FFFF_FFFF;
   localparam logic signed [34:0] PiQ30 = 35'sd3373259426;
   localparam logic signed [34:0] HalfPiQ30 = 35'sd1686629713;
   localparam logic signed [34:0] TwoPiQ30 = 35'sd6746518852;
   localparam logic signed [AngW-1:0] GainQ30 = 33'sd652032874;

   localparam logic [31:0] AtanQ30 [AtanEntries] = '{
      32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
      32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
      32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
      32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
   };

   typedef enum logic [2:0] {
      SEQ_TG, SEQ_A, SEQ_DIVQ, SEQ_DIVM, SEQ_IDLE
   } seq_state_type;

   typedef struct packed {
      logic                   neg;
      logic signed [AngW-1:0] z;
   } angle_type;

   // fold a Q.30 angle into [-pi/2, pi/2]
   function automatic angle_type fold_angle(input logic signed [34:0] z_raw);
      logic signed [34:0] z;
      angle_type          res;
      z = z_raw;
      if (z > PiQ30) z = z - TwoPiQ30;
      else if (z < -PiQ30) z = z + TwoPiQ30;
      res.neg = 1'b0;
      if (z > HalfPiQ30) begin
         z = z - PiQ30;
         res.neg = 1'b1;
      end else if (z < -HalfPiQ30) begin
         z = z + PiQ30;
         res.neg = 1'b1;
      end
      res.z = z[AngW-1:0];
      return res;
   endfunction

   function automatic logic [33:0] sat34(input logic [DivW-1:0] v);
      return (|v[DivW-1:34]) ? Lim34 : v[33:0];
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [PrdW-1:0] v);
      if (v > PrdW'(64'sd2147483647)) return 32'sh7FFF_FFFF;
      if (v < -PrdW'(64'sd2147483648)) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   // (p + 2^27) >> 28, arithmetic
   function automatic logic signed [PrdW-1:0] rnd28(input logic signed [PrdW-1:0] p);
      return (p + PrdW'(64'sd134217728)) >>> 28;
   endfunction

   // rounded shift of the negated product, without a second multiply
   function automatic logic signed [PrdW-1:0] rnd28_neg(input logic signed [PrdW-1:0] p);
      return -((p + PrdW'(64'sd134217727)) >>> 28);
   endfunction

endpackage
`default_nettype wire

// ===== src/planar_lander_dynamics_jacobian_unit.sv =====
`default_nettype none
// Planar lander dynamics and Jacobian unit. Each transfer on the req_ channel
// (throttle Q1.15, gimbal and pitch angles Q3.13 rad) yields one transfer on
// the rsp_ channel with the accelerations and the non-trivial Jacobian entries,
// all Q16.16 saturated to 32 bits. The pipeline (input register, angle fold, one
// register per CORDIC iteration, sine/cosine rounding, multiply, output register)
// takes one item per cycle when rsp_ready is high and no precompute runs. The
// rsp_ stage is a register, so new items keep entering while a result waits,
// until every stage is full. Writing any csr_ register, and leaving reset, starts
// a precompute of the config-only terms (thrust-to-weight times gravity, and the
// torque gain that needs two divisions by the gyration radius) on a bit-serial
// divider; req_ready stays low until it ends. Write config only while idle.
module planar_lander_dynamics_jacobian_unit #(
   parameter int CORDIC_STAGES = pldj_pkg::CordicStagesDefault
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_wen,
   input  wire logic [1:0]             csr_index,
   input  wire logic [pldj_pkg::CfgW-1:0] csr_wdata,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [15:0]            req_throttle,
   input  wire logic signed [15:0]     req_gimbal_angle,
   input  wire logic signed [15:0]     req_pitch_angle,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic signed [31:0]          rsp_accel_x,
   output logic signed [31:0]          rsp_accel_y,
   output logic signed [31:0]          rsp_angular_accel,
   output logic signed [31:0]          rsp_dax_dpitch,
   output logic signed [31:0]          rsp_day_dpitch,
   output logic signed [31:0]          rsp_dax_dthrottle,
   output logic signed [31:0]          rsp_dax_dgimbal,
   output logic signed [31:0]          rsp_day_dthrottle,
   output logic signed [31:0]          rsp_day_dgimbal,
   output logic signed [31:0]          rsp_dw_dthrottle,
   output logic signed [31:0]          rsp_dw_dgimbal
);
   import pldj_pkg::*;

   localparam int NS   = CORDIC_STAGES + 5;   // pipeline stages
   localparam int SSC  = CORDIC_STAGES + 2;   // sine/cosine stage
   localparam int SMUL = CORDIC_STAGES + 3;   // product stage
   localparam int SOUT = CORDIC_STAGES + 4;   // output register
   localparam int CntW = $clog2(DivW);

   // ---------------- configuration registers ----------------
   logic [CfgW-1:0] twr_ff, grv_ff, arm_ff, gyr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         twr_ff <= TwrReset;
         grv_ff <= GrvReset;
         arm_ff <= ArmReset;
         gyr_ff <= GyrReset;
      end else if (csr_wen) begin
         case (csr_index)
            CsrTwr:  twr_ff <= csr_wdata;
            CsrGrv:  grv_ff <= csr_wdata;
            CsrArm:  arm_ff <= csr_wdata;
            CsrGyr:  gyr_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------- config precompute sequencer ----------------
   seq_state_type    seq_ff, seq_in;
   logic [31:0]      tg_ff, tg_in;
   logic [33:0]      m_ff, m_in;
   logic [DivW-1:0]  dnum_ff, dnum_in, quot_ff, quot_in;
   logic [CfgW-1:0]  rem_ff, rem_in;
   logic [CntW-1:0]  cnt_ff, cnt_in;
   logic [CfgW-1:0]  gd;
   logic [47:0]      tg_prod;
   logic [55:0]      a_prod;
   logic [CfgW:0]    trial;
   logic             qbit;

   assign gd      = (gyr_ff == '0) ? CfgW'(1) : gyr_ff;
   assign tg_prod = twr_ff * grv_ff + 48'd32768;
   assign a_prod  = tg_ff * arm_ff + 56'd32768;
   assign trial   = {rem_ff, dnum_ff[DivW-1]};
   assign qbit    = (trial >= {1'b0, gd});

   always_comb begin
      seq_in  = seq_ff;
      tg_in   = tg_ff;
      m_in    = m_ff;
      dnum_in = dnum_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      case (seq_ff)
         SEQ_TG: begin
            tg_in  = tg_prod[47:16];
            seq_in = SEQ_A;
         end
         SEQ_A: begin
            dnum_in = {a_prod[55:16], 16'b0};
            rem_in  = '0;
            cnt_in  = '0;
            seq_in  = SEQ_DIVQ;
         end
         SEQ_DIVQ, SEQ_DIVM: begin
            // restoring division, one quotient bit a cycle
            rem_in  = qbit ? CfgW'(trial - {1'b0, gd}) : trial[CfgW-1:0];
            dnum_in = {dnum_ff[DivW-2:0], 1'b0};
            quot_in = {quot_ff[DivW-2:0], qbit};
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == CntW'(DivW - 1)) begin
               if (seq_ff == SEQ_DIVQ) begin
                  dnum_in = {6'b0, sat34(quot_in), 16'b0};
                  rem_in  = '0;
                  cnt_in  = '0;
                  seq_in  = SEQ_DIVM;
               end else begin
                  m_in   = sat34(quot_in);
                  seq_in = SEQ_IDLE;
               end
            end
         end
         default: ;
      endcase
      if (csr_wen) seq_in = SEQ_TG;   // restart on any write
   end

   always_ff @(posedge clock) begin
      if (reset) seq_ff <= SEQ_TG;
      else       seq_ff <= seq_in;
   end

   always_ff @(posedge clock) begin
      tg_ff   <= tg_in;
      m_ff    <= m_in;
      dnum_ff <= dnum_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
   end

   // ---------------- pipeline flow control ----------------
   // a stage loads when it is empty or its successor loads
   logic [NS-1:0] v_ff;
   logic [NS-1:0] rdy;

   always_comb begin
      rdy[NS-1] = !v_ff[NS-1] || rsp_ready;
      for (int k = NS - 2; k >= 0; k--) rdy[k] = !v_ff[k] || rdy[k+1];
   end

   assign req_ready = rdy[0] && (seq_ff == SEQ_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (rdy[0]) v_ff[0] <= req_valid && req_ready;
         for (int k = 1; k < NS; k++) begin
            if (rdy[k]) v_ff[k] <= v_ff[k-1];
         end
      end
   end

   // ---------------- stage 0: input register ----------------
   logic [15:0]        thr0_ff;
   logic signed [16:0] za0_ff;
   logic signed [15:0] zb0_ff;

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         thr0_ff <= req_throttle;
         za0_ff  <= 17'(req_gimbal_angle) + 17'(req_pitch_angle);
         zb0_ff  <= req_gimbal_angle;
      end
   end

   // ---------------- stage 1: fold angles, force terms ----------------
   logic [32:0] f_raw;   // tg*thr + round, shifted
   logic [49:0] k_prod;
   logic [47:0] f_prod;
   angle_type   fa, fb;

   assign f_prod = tg_ff * thr0_ff + 48'd16384;
   assign f_raw  = f_prod[47:15];
   assign k_prod = m_ff * thr0_ff + 50'd16384;
   assign fa     = fold_angle({za0_ff[16], za0_ff, 17'b0});
   assign fb     = fold_angle({{2{zb0_ff[15]}}, zb0_ff, 17'b0});

   // CORDIC working set: index j holds the state after j iterations
   logic signed [AngW-1:0] xa_ff [CORDIC_STAGES+1];
   logic signed [AngW-1:0] ya_ff [CORDIC_STAGES+1];
   logic signed [AngW-1:0] za_ff [CORDIC_STAGES+1];
   logic signed [AngW-1:0] xb_ff [CORDIC_STAGES+1];
   logic signed [AngW-1:0] yb_ff [CORDIC_STAGES+1];
   logic signed [AngW-1:0] zb_ff [CORDIC_STAGES+1];
   logic                   nega_ff [CORDIC_STAGES+1];
   logic                   negb_ff [CORDIC_STAGES+1];
   logic [32:0]            f_ff [CORDIC_STAGES+1];
   logic [33:0]            k_ff [CORDIC_STAGES+1];

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         xa_ff[0]   <= GainQ30;
         ya_ff[0]   <= '0;
         za_ff[0]   <= fa.z;
         nega_ff[0] <= fa.neg;
         xb_ff[0]   <= GainQ30;
         yb_ff[0]   <= '0;
         zb_ff[0]   <= fb.z;
         negb_ff[0] <= fb.neg;
         f_ff[0]    <= f_raw;
         k_ff[0]    <= (|k_prod[49:49]) ? Lim34 : k_prod[48:15];
      end
   end

   // ---------------- CORDIC iterations, one register each ----------------
   for (genvar gi = 0; gi < CORDIC_STAGES; gi++) begin : g_cordic
      localparam logic signed [AngW-1:0] Atan = AngW'(AtanQ30[gi]);
      always_ff @(posedge clock) begin
         if (rdy[gi+2]) begin
            if (za_ff[gi] >= 0) begin
               xa_ff[gi+1] <= xa_ff[gi] - (ya_ff[gi] >>> gi);
               ya_ff[gi+1] <= ya_ff[gi] + (xa_ff[gi] >>> gi);
               za_ff[gi+1] <= za_ff[gi] - Atan;
            end else begin
               xa_ff[gi+1] <= xa_ff[gi] + (ya_ff[gi] >>> gi);
               ya_ff[gi+1] <= ya_ff[gi] - (xa_ff[gi] >>> gi);
               za_ff[gi+1] <= za_ff[gi] + Atan;
            end
            if (zb_ff[gi] >= 0) begin
               xb_ff[gi+1] <= xb_ff[gi] - (yb_ff[gi] >>> gi);
               yb_ff[gi+1] <= yb_ff[gi] + (xb_ff[gi] >>> gi);
               zb_ff[gi+1] <= zb_ff[gi] - Atan;
            end else begin
               xb_ff[gi+1] <= xb_ff[gi] + (yb_ff[gi] >>> gi);
               yb_ff[gi+1] <= yb_ff[gi] - (xb_ff[gi] >>> gi);
               zb_ff[gi+1] <= zb_ff[gi] + Atan;
            end
            nega_ff[gi+1] <= nega_ff[gi];
            negb_ff[gi+1] <= negb_ff[gi];
            f_ff[gi+1]    <= f_ff[gi];
            k_ff[gi+1]    <= k_ff[gi];
         end
      end
   end

   // ---------------- sine/cosine: undo fold, round Q.30 to Q.28 ----------------
   logic signed [AngW-1:0] sa_ff, ca_ff, sb_ff, cb_ff;
   logic signed [AngW-1:0] xa_n, ya_n, xb_n, yb_n;
   logic [32:0]            fs_ff;
   logic [33:0]            ks_ff;

   assign xa_n = nega_ff[CORDIC_STAGES] ? -xa_ff[CORDIC_STAGES] : xa_ff[CORDIC_STAGES];
   assign ya_n = nega_ff[CORDIC_STAGES] ? -ya_ff[CORDIC_STAGES] : ya_ff[CORDIC_STAGES];
   assign xb_n = negb_ff[CORDIC_STAGES] ? -xb_ff[CORDIC_STAGES] : xb_ff[CORDIC_STAGES];
   assign yb_n = negb_ff[CORDIC_STAGES] ? -yb_ff[CORDIC_STAGES] : yb_ff[CORDIC_STAGES];

   always_ff @(posedge clock) begin
      if (rdy[SSC]) begin
         sa_ff <= (ya_n + AngW'(2)) >>> 2;
         ca_ff <= (xa_n + AngW'(2)) >>> 2;
         sb_ff <= (yb_n + AngW'(2)) >>> 2;
         cb_ff <= (xb_n + AngW'(2)) >>> 2;
         fs_ff <= f_ff[CORDIC_STAGES];
         ks_ff <= k_ff[CORDIC_STAGES];
      end
   end

   // ---------------- products ----------------
   logic signed [PrdW-1:0] p_fsa_ff, p_fca_ff, p_ksb_ff, p_kcb_ff;
   logic signed [PrdW-1:0] p_tsa_ff, p_tca_ff, p_msb_ff;
   logic signed [33:0]     f_s;
   logic signed [34:0]     k_s, m_s;
   logic signed [32:0]     t_s;

   assign f_s = {1'b0, fs_ff};
   assign k_s = {1'b0, ks_ff};
   assign m_s = {1'b0, m_ff};
   assign t_s = {1'b0, tg_ff};

   // widen both operands so the full product is kept
   always_ff @(posedge clock) begin
      if (rdy[SMUL]) begin
         p_fsa_ff <= PrdW'(f_s) * PrdW'(sa_ff);
         p_fca_ff <= PrdW'(f_s) * PrdW'(ca_ff);
         p_ksb_ff <= PrdW'(k_s) * PrdW'(sb_ff);
         p_kcb_ff <= PrdW'(k_s) * PrdW'(cb_ff);
         p_tsa_ff <= PrdW'(t_s) * PrdW'(sa_ff);
         p_tca_ff <= PrdW'(t_s) * PrdW'(ca_ff);
         p_msb_ff <= PrdW'(m_s) * PrdW'(sb_ff);
      end
   end

   // ---------------- output register: round, sign, saturate ----------------
   logic signed [PrdW-1:0] grav_s;
   assign grav_s = PrdW'({1'b0, grv_ff});

   always_ff @(posedge clock) begin
      if (rdy[SOUT]) begin
         rsp_accel_x       <= sat32(rnd28(p_fsa_ff));
         rsp_accel_y       <= sat32(rnd28(p_fca_ff) - grav_s);
         rsp_angular_accel <= sat32(rnd28_neg(p_ksb_ff));
         rsp_dax_dpitch    <= sat32(rnd28(p_fca_ff));
         rsp_day_dpitch    <= sat32(rnd28_neg(p_fsa_ff));
         rsp_dax_dthrottle <= sat32(rnd28(p_tsa_ff));
         rsp_dax_dgimbal   <= sat32(rnd28(p_fca_ff));
         rsp_day_dthrottle <= sat32(rnd28(p_tca_ff));
         rsp_day_dgimbal   <= sat32(rnd28_neg(p_fsa_ff));
         rsp_dw_dthrottle  <= sat32(rnd28_neg(p_msb_ff));
         rsp_dw_dgimbal    <= sat32(rnd28_neg(p_kcb_ff));
      end
   end

   assign rsp_valid = v_ff[SOUT];

   // ---------------- assertions ----------------
   a_ready_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready) else $error("ready right after reset");
   a_no_accept_precompute: assert property (@(posedge clock) disable iff (reset)
      (seq_ff != SEQ_IDLE) |-> !req_ready) else $error("accept during precompute");
   a_dax_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_dax_dpitch == rsp_dax_dgimbal) else $error("dax pair differs");
   a_day_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_day_dpitch == rsp_day_dgimbal) else $error("day pair differs");

endmodule
`default_nettype wire
